@@ rtl/bounded_priority_job_queue_top_defines.svh @@
// ----------------------------------------------------------------------------
// Bounded priority job queue assertion macros
// Assertion wrappers used by the controller; they compile to nothing in SYNTH.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH
`define BOUNDED_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked property, held off while reset is asserted.
`define BPJQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpjq assertion failed");
// Checked property that also holds during reset.
`define BPJQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bpjq assertion failed");
`else
`define BPJQ_ASSERT(lbl, clk, rst_n, prop)
`define BPJQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/bpjq_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded priority job queue package
// Shared constants, job record type, codes and controller-to-datapath bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpjq_pkg;

    localparam int DEPTH  = 8;
    localparam int FILL_W = $clog2(DEPTH + 1);

    localparam int PRIO_W  = 4;
    localparam int CTIME_W = 3;
    localparam int PROD_W  = 8;
    localparam int PID_W   = 22;
    localparam int JID_W   = 17;
    localparam int QUOTA_W = 16;

    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [QUOTA_W-1:0] t_quota;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [CTIME_W-1:0] ctime;
        logic [PROD_W-1:0]  prod;
        logic [PID_W-1:0]   pid;
        logic [JID_W-1:0]   jid;
    } t_job;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_QUOTA = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic  load;   // a request was accepted; update the result job
        logic  push;   // insert the new job in sorted place
        logic  pop;    // remove the top job and present it
        t_fill fill;   // entries held before this request
    } t_dp_ctrl;

endpackage

@@ rtl/bpjq_datapath.sv @@
// ----------------------------------------------------------------------------
// Bounded priority job queue datapath
// Row of job slots kept in descending priority order plus the result job register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpjq_datapath (
    input  logic              i_clk,
    input  bpjq_pkg::t_dp_ctrl i_ctrl,
    input  bpjq_pkg::t_job     i_job,
    output bpjq_pkg::t_job     o_job
);
    import bpjq_pkg::*;

    // Slot 0 holds the job served next; higher slots hold equal or lower priorities.
    t_job             r_slot [DEPTH];
    t_job             n_slot [DEPTH];
    logic [DEPTH-1:0] gt;
    t_job             r_out;
    t_job             n_out;

    // Each held slot compares itself with the new priority in parallel.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            gt[k] = (FILL_W'(k) < i_ctrl.fill) && (r_slot[k].prio > i_job.prio);
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        always_comb begin
            n_slot[k] = r_slot[k];
            if (i_ctrl.push) begin
                if (!gt[k]) begin
                    if (k == 0) begin
                        n_slot[k] = i_job;
                    end else if (gt[(k > 0) ? k - 1 : 0]) begin
                        n_slot[k] = i_job;
                    end else begin
                        n_slot[k] = r_slot[(k > 0) ? k - 1 : 0];
                    end
                end
            end else if (i_ctrl.pop) begin
                if (k < DEPTH - 1) begin
                    n_slot[k] = r_slot[(k < DEPTH - 1) ? k + 1 : k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot[k] <= n_slot[k];
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_ctrl.load) begin
            n_out = i_ctrl.pop ? r_slot[0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_job = r_out;

endmodule

@@ rtl/bpjq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bounded priority job queue controller
// Checks room and quota, keeps the counters and sequences the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_priority_job_queue_top_defines.svh"

module bpjq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bpjq_pkg::t_cmd      i_command,
    input  logic                i_cfg_we,
    input  bpjq_pkg::t_quota    i_cfg_wdata,
    output bpjq_pkg::t_dp_ctrl  o_ctrl,
    output logic                o_valid,
    output bpjq_pkg::t_status   o_status,
    output bpjq_pkg::t_fill     o_occupancy
);
    import bpjq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_fill   r_fill, n_fill;
    t_quota  r_created, n_created;
    t_quota  r_completed, n_completed;
    t_quota  r_total;
    t_status r_status, n_status;
    logic    push_ok;
    logic    pop_ok;
    t_status dec_status;

    // Room is checked before the quota on both commands.
    always_comb begin
        push_ok    = 1'b0;
        pop_ok     = 1'b0;
        dec_status = STAT_DONE;
        unique case (i_command)
            CMD_PUSH: begin
                if (r_fill == FILL_W'(DEPTH)) begin
                    dec_status = STAT_FULL;
                end else if (r_total <= r_created) begin
                    dec_status = STAT_QUOTA;
                end else begin
                    push_ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (r_fill == '0) begin
                    dec_status = STAT_EMPTY;
                end else if (r_total <= r_completed) begin
                    dec_status = STAT_QUOTA;
                end else begin
                    pop_ok = 1'b1;
                end
            end
            default: dec_status = STAT_DONE;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_created   = r_created;
        n_completed = r_completed;
        n_status    = r_status;
        if (i_accept) begin
            n_status = dec_status;
            if (push_ok) begin
                n_fill    = r_fill + FILL_W'(1);
                n_created = r_created + QUOTA_W'(1);
            end else if (pop_ok) begin
                n_fill      = r_fill - FILL_W'(1);
                n_completed = r_completed + QUOTA_W'(1);
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE, S_RESULT: n_state = i_accept ? S_RESULT : S_IDLE;
            default:          n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_created   <= '0;
            r_completed <= '0;
            r_total     <= '0;
            r_status    <= STAT_DONE;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_created   <= n_created;
            r_completed <= n_completed;
            r_status    <= n_status;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
        end
    end

    assign o_ctrl.load  = i_accept;
    assign o_ctrl.push  = i_accept && push_ok;
    assign o_ctrl.pop   = i_accept && pop_ok;
    assign o_ctrl.fill  = r_fill;
    assign o_valid      = (r_state == S_RESULT);
    assign o_status     = r_status;
    assign o_occupancy  = r_fill;

    `BPJQ_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(DEPTH))
    `BPJQ_ASSERT(a_accept_gives_result, i_clk, i_rst_n, i_accept |=> o_valid)
    `BPJQ_ASSERT(a_push_grows, i_clk, i_rst_n,
        (i_accept && push_ok) |=> (r_fill == $past(r_fill) + FILL_W'(1)))
    `BPJQ_ASSERT(a_pop_counts, i_clk, i_rst_n,
        (i_accept && pop_ok) |=> (r_completed == $past(r_completed) + QUOTA_W'(1)))
    `BPJQ_ASSERT(a_done_status, i_clk, i_rst_n,
        (i_accept && (push_ok || pop_ok)) |=> (o_status == STAT_DONE))

endmodule

@@ rtl/bounded_priority_job_queue_top.sv @@
// ----------------------------------------------------------------------------
// Bounded priority job queue
// Fixed-depth job queue kept sorted by priority, with create and complete quotas.
// ----------------------------------------------------------------------------
// The queue takes one request in every clock cycle: busy is always low, so a
// request is accepted at any rising edge with start high. Its result appears on
// the o_ ports in the following cycle, marked by o_valid for exactly that one
// cycle; the receiver cannot stall, so it must capture the result then. Each
// request is done in one step because every held slot compares itself with the new
// priority in parallel and shifts by at most one place in a single step. A push
// goes in below all jobs of higher priority and above jobs of equal or lower
// priority, so a pop returns the highest priority and, among equals, the newest
// job. A push is refused with status full when all slots are held and with
// status quota when total_jobs jobs have already been created; a pop is refused
// with status empty or quota in the same order. Refused requests return zero in
// the job fields and change nothing. Write total_jobs only while no request is
// in flight. The occupancy reported is the count after the request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_priority_job_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request channel.
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [bpjq_pkg::PRIO_W-1:0]         i_job_priority,
    input  logic [bpjq_pkg::CTIME_W-1:0]        i_job_compute_time,
    input  logic [bpjq_pkg::PROD_W-1:0]         i_producer_number,
    input  logic [bpjq_pkg::PID_W-1:0]          i_process_ident,
    input  logic [bpjq_pkg::JID_W-1:0]          i_job_ident,
    // Quota register write port.
    input  logic                                i_cfg_we,
    input  logic [bpjq_pkg::QUOTA_W-1:0]        i_cfg_wdata,
    // Result channel.
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [bpjq_pkg::PRIO_W-1:0]         o_out_priority,
    output logic [bpjq_pkg::CTIME_W-1:0]        o_out_compute_time,
    output logic [bpjq_pkg::PROD_W-1:0]         o_out_producer,
    output logic [bpjq_pkg::PID_W-1:0]          o_out_process_ident,
    output logic [bpjq_pkg::JID_W-1:0]          o_out_job_ident,
    output logic [bpjq_pkg::FILL_W-1:0]         o_occupancy
);
    import bpjq_pkg::*;

    logic     accept;
    t_dp_ctrl ctrl;
    t_job     new_job;
    t_job     res_job;
    t_status  status;
    t_cmd     command;

    // The queue never holds a request off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign command       = t_cmd'(i_command);
    assign new_job.prio  = i_job_priority;
    assign new_job.ctime = i_job_compute_time;
    assign new_job.prod  = i_producer_number;
    assign new_job.pid   = i_process_ident;
    assign new_job.jid   = i_job_ident;

    // The controller decides each request from the fill count and the quotas.
    bpjq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (command),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctrl      (ctrl),
        .o_valid     (o_valid),
        .o_status    (status),
        .o_occupancy (o_occupancy)
    );

    // The datapath holds the sorted slots and the popped job.
    bpjq_datapath u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_job  (new_job),
        .o_job  (res_job)
    );

    assign o_status            = status;
    assign o_out_priority      = res_job.prio;
    assign o_out_compute_time  = res_job.ctime;
    assign o_out_producer      = res_job.prod;
    assign o_out_process_ident = res_job.pid;
    assign o_out_job_ident     = res_job.jid;

endmodule
